### sv/sacl_pkg.sv
// Package with the shared types and constants of the substring count and locate block.
package sacl_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAT_BYTES = 8;
  localparam int unsigned PAT_W     = PAT_BYTES * BYTE_W;
  localparam int unsigned PLEN_W    = 4;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [RES_W-1:0] match_count;
    logic             found_any;
    logic [RES_W-1:0] first_start;
    logic [RES_W-1:0] last_start;
    logic             too_long;
  } search_result_t;

endpackage

### sv/substring_count_and_locate.sv
// Top level of the substring count and locate block.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   text    | in        | text_valid / text_ready    | text_item_t (byte, end flag)
//   result  | out       | result_valid / result_ready| search_result_t
//   cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data (64 bits)
//
// A text transaction is captured in an input stage register, and the window compare and all
// counters update from the stage in a single pass; one text byte per clock is sustained while
// no string-ending byte waits on a full result register, which takes that byte's result.
// Reset is synchronous and clears the stage, the result register and all string state.
// A stalled result stalls the input stage only when the stage must hand over; the
// result register lets the next byte enter while a finished result waits.
module substring_count_and_locate
  import sacl_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned TEXT_MAX    = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  text_item_t            text,
  output logic                  result_valid,
  input  logic                  result_ready,
  output search_result_t        result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAT_W-1:0]      cfg_data
);

  // Byte index must be able to hold TEXT_MAX itself; positions need one bit less.
  localparam int unsigned IDX_W = $clog2(TEXT_MAX) + 1;
  localparam int unsigned POS_W = IDX_W - 1;
  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  // Configuration registers.
  logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
  logic [PLEN_W-1:0]                pattern_length;

  // Input stage.
  logic       stage_valid;
  text_item_t stage;

  // Per-string state.
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window, window_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [IDX_W-1:0] next_allowed, next_allowed_next;
  logic [RES_W-1:0] running_count, running_count_next;
  logic [POS_W-1:0] leftmost, leftmost_next;
  logic             leftmost_valid, leftmost_valid_next;
  logic [POS_W-1:0] rightmost, rightmost_next;
  logic             overflowed, overflowed_next;

  logic           advance;
  logic [LEN_W-1:0] eff_len;
  logic           hit;
  logic [IDX_W-1:0] index_plus1;
  logic [IDX_W-1:0] start;
  search_result_t result_next;

  // Configuration is always taken; the user must write the port only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  pattern        <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        default:            pattern        <= pattern;
      endcase
    end
  end

  // A byte that ends a string waits until the result register can take its result; any
  // other byte moves on at once.
  assign advance    = stage_valid && (!stage.end_of_text || !result_valid || result_ready);
  assign text_ready = !stage_valid || advance;

  // A pattern length beyond the window depth is clamped to the depth.
  assign eff_len = (pattern_length > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : LEN_W'(pattern_length);
  assign index_plus1 = byte_index + IDX_W'(1);
  assign start       = index_plus1 - IDX_W'(eff_len);

  // Shifted window, newest byte at index 0, and the parallel compare against the pattern.
  always_comb begin
    logic [PLEN_W-1:0] pidx;
    window_next[0] = stage.text_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
    hit = (eff_len != '0) && (index_plus1 >= IDX_W'(eff_len));
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pidx = PLEN_W'(eff_len) - PLEN_W'(k) - PLEN_W'(1);
      if ((LEN_W'(k) < eff_len) && (window_next[k] != pattern[pidx[2:0]])) begin
        hit = 1'b0;
      end
    end
  end

  // String state update for the byte in the stage.
  always_comb begin
    byte_index_next     = byte_index;
    next_allowed_next   = next_allowed;
    running_count_next  = running_count;
    leftmost_next       = leftmost;
    leftmost_valid_next = leftmost_valid;
    rightmost_next      = rightmost;
    overflowed_next     = overflowed;
    if (byte_index >= IDX_W'(TEXT_MAX)) begin
      // Bytes past the length limit are dropped but still mark the string.
      overflowed_next = 1'b1;
    end else begin
      byte_index_next = index_plus1;
      if (hit) begin
        if (!leftmost_valid) begin
          leftmost_next       = start[POS_W-1:0];
          leftmost_valid_next = 1'b1;
        end
        rightmost_next = start[POS_W-1:0];
        // Greedy count: a match only counts if it starts at or after the end of the last counted one.
        if (start >= next_allowed) begin
          if (running_count != '1) begin
            running_count_next = running_count + RES_W'(1);
          end
          next_allowed_next = index_plus1;
        end
      end
    end
  end

  always_comb begin
    result_next.match_count = running_count_next;
    result_next.found_any   = leftmost_valid_next;
    result_next.first_start = leftmost_valid_next ? RES_W'(leftmost_next) : '0;
    result_next.last_start  = leftmost_valid_next ? RES_W'(rightmost_next) : '0;
    result_next.too_long    = overflowed_next;
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_ready) begin
      stage_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ready && text_valid) begin
      stage <= text;
    end
  end

  // String state: cleared after the byte that ends a string.
  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      byte_index     <= '0;
      next_allowed   <= '0;
      running_count  <= '0;
      leftmost       <= '0;
      leftmost_valid <= 1'b0;
      rightmost      <= '0;
      overflowed     <= 1'b0;
    end else if (advance) begin
      if (stage.end_of_text) begin
        window         <= '0;
        byte_index     <= '0;
        next_allowed   <= '0;
        running_count  <= '0;
        leftmost       <= '0;
        leftmost_valid <= 1'b0;
        rightmost      <= '0;
        overflowed     <= 1'b0;
      end else begin
        if (byte_index < IDX_W'(TEXT_MAX)) begin
          window <= window_next;
        end
        byte_index     <= byte_index_next;
        next_allowed   <= next_allowed_next;
        running_count  <= running_count_next;
        leftmost       <= leftmost_next;
        leftmost_valid <= leftmost_valid_next;
        rightmost      <= rightmost_next;
        overflowed     <= overflowed_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage.end_of_text) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.end_of_text) begin
      result <= result_next;
    end
  end

  // A result with no occurrence reports zero positions.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found_any) |-> (result.first_start == '0 &&
                                             result.last_start == '0))
    else $error("positions nonzero without an occurrence");

  // The leftmost occurrence never starts after the rightmost one.
  a_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found_any) |-> (result.first_start <= result.last_start))
    else $error("leftmost start after rightmost start");

  // Any occurrence is also counted, and a count implies an occurrence.
  a_count_found: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.match_count != '0) == result.found_any))
    else $error("count and found flag disagree");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

endmodule
